// ----- rtl/bdac_pkg.sv -----
`timescale 1ns / 1ps

package bdac_pkg;

   // Width of the binary number, 4 to 64.
   localparam int INPUT_BITS = 64;

   // Decimal digits needed for 2^INPUT_BITS - 1: floor(bits * log10(2)) + 1.
   localparam int DIGITS = (INPUT_BITS * 30103) / 100000 + 1;

   localparam int BIT_CNT_W = $clog2(INPUT_BITS);
   localparam int REM_W     = $clog2(DIGITS + 1);

   localparam logic [5:0] ASCII_ZERO = 6'd48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   // Control common to every cell of the digit chain.
   typedef struct packed {
      logic clear;
      logic shift_bit;
      logic shift_digit;
   } cell_ctrl_type;

endpackage

// ----- rtl/bdac_cell.sv -----
`timescale 1ns / 1ps

// One BCD digit of the double-dabble chain.
module bdac_cell (
   input  logic                    clock,
   input  bdac_pkg::cell_ctrl_type ctrl,
   input  logic                    bit_in,
   input  logic [3:0]              digit_in,
   output logic                    bit_out,
   output logic [3:0]              digit_out
);

   logic [3:0] digit_ff;
   logic [3:0] digit_next_in;
   logic [3:0] adjusted;

   // Add three to digits of five and above before the shift.
   assign adjusted  = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign bit_out   = adjusted[3];
   assign digit_out = digit_ff;

   always_comb begin
      priority if (ctrl.clear) begin
         digit_next_in = 4'd0;
      end else if (ctrl.shift_bit) begin
         digit_next_in = {adjusted[2:0], bit_in};
      end else if (ctrl.shift_digit) begin
         digit_next_in = digit_in;
      end else begin
         digit_next_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_next_in;
   end

endmodule

// ----- rtl/bdac_chain.sv -----
`timescale 1ns / 1ps

// Row of BCD cells: bits enter at cell 0, digits leave at the top cell.
module bdac_chain (
   input  logic                    clock,
   input  bdac_pkg::cell_ctrl_type ctrl,
   input  logic                    bit_in,
   output logic [3:0]              top_digit
);

   logic       carry  [bdac_pkg::DIGITS];
   logic [3:0] digits [bdac_pkg::DIGITS];

   for (genvar i = 0; i < bdac_pkg::DIGITS; i++) begin : g_cell
      logic       cell_bit_in;
      logic [3:0] cell_digit_in;

      if (i == 0) begin : g_first
         assign cell_bit_in   = bit_in;
         assign cell_digit_in = 4'd0;
      end else begin : g_next
         assign cell_bit_in   = carry[i-1];
         assign cell_digit_in = digits[i-1];
      end

      bdac_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .bit_in    (cell_bit_in),
         .digit_in  (cell_digit_in),
         .bit_out   (carry[i]),
         .digit_out (digits[i])
      );
   end

   assign top_digit = digits[bdac_pkg::DIGITS-1];

endmodule

// ----- rtl/binary_to_decimal_ascii_top.sv -----
`timescale 1ns / 1ps
// After the transfer, double dabble shifts the number into the cell chain one bit per
//   cycle, leading zeros are then dropped, then digits leave one per cycle unless stalled.
// A new number is taken only in the idle state, after the last digit of the previous one
//   has been loaded into the output register.
// Reset: synchronous, active high; clears the controller and the output valid.
module binary_to_decimal_ascii_top (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bdac_pkg::INPUT_BITS-1:0] req_value,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [5:0]                      rsp_digit_char,
   output logic                            rsp_last_digit
);

   localparam int W = bdac_pkg::INPUT_BITS;

   bdac_pkg::state_type state_ff, state_in;

   logic [W-1:0]                   value_ff, value_in;
   logic [bdac_pkg::BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [bdac_pkg::REM_W-1:0]     rem_ff, rem_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [5:0] rsp_digit_char_ff, rsp_digit_char_in;
   logic       rsp_last_digit_ff, rsp_last_digit_in;

   bdac_pkg::cell_ctrl_type ctrl;
   logic [3:0] top_digit;
   logic       req_xfer;
   logic       out_free;
   logic       out_load;
   logic       last_bit;
   logic       lead_zero;
   logic       last_one;

   // The digit chain: bits shift in from the binary register's top bit,
   // digits shift out of the top cell, most significant first.
   bdac_chain u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .bit_in    (value_ff[W-1]),
      .top_digit (top_digit)
   );

   assign req_xfer  = req_valid && (state_ff == bdac_pkg::ST_IDLE);
   // Output register can take a digit when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_bit  = (cnt_ff == bdac_pkg::BIT_CNT_W'(W - 1));
   assign last_one  = (rem_ff == bdac_pkg::REM_W'(1));
   // A leading zero is dropped, but never the final digit.
   assign lead_zero = (top_digit == 4'd0) && !last_one;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bdac_pkg::ST_IDLE: begin
            if (req_valid) state_in = bdac_pkg::ST_CONVERT;
         end
         bdac_pkg::ST_CONVERT: begin
            if (last_bit) state_in = bdac_pkg::ST_SKIP;
         end
         bdac_pkg::ST_SKIP: begin
            if (!lead_zero) state_in = bdac_pkg::ST_EMIT;
         end
         bdac_pkg::ST_EMIT: begin
            if (out_free && last_one) state_in = bdac_pkg::ST_IDLE;
         end
         default: state_in = bdac_pkg::ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      ctrl        = '0;
      out_load    = 1'b0;
      req_stall   = 1'b1;
      unique case (state_ff)
         bdac_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            ctrl.clear = req_valid;
         end
         bdac_pkg::ST_CONVERT: begin
            ctrl.shift_bit = 1'b1;
         end
         bdac_pkg::ST_SKIP: begin
            ctrl.shift_digit = lead_zero;
         end
         bdac_pkg::ST_EMIT: begin
            out_load         = out_free;
            ctrl.shift_digit = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      value_in = value_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      if (req_xfer) begin
         // Hold the number and restart the bit count.
         value_in = req_value;
         cnt_in   = '0;
      end else if (ctrl.shift_bit) begin
         value_in = {value_ff[W-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
      end
      if (ctrl.shift_bit && last_bit) begin
         rem_in = bdac_pkg::REM_W'(bdac_pkg::DIGITS);
      end else if (ctrl.shift_digit) begin
         rem_in = rem_ff - 1'b1;
      end
   end

   // Output register: load on a free slot, drop after a transfer, else hold.
   always_comb begin
      rsp_digit_char_in = rsp_digit_char_ff;
      rsp_last_digit_in = rsp_last_digit_ff;
      priority if (out_load) begin
         rsp_valid_in      = 1'b1;
         rsp_digit_char_in = bdac_pkg::ASCII_ZERO + {2'b00, top_digit};
         rsp_last_digit_in = last_one;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdac_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff          <= value_in;
      rsp_digit_char_ff <= rsp_digit_char_in;
      rsp_last_digit_ff <= rsp_last_digit_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_digit_char_ff;
   assign rsp_last_digit = rsp_last_digit_ff;

endmodule

// ----- rtl/bdac_checker.sv -----
`timescale 1ns / 1ps

module bdac_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [5:0] rsp_digit_char,
   input logic       rsp_last_digit
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digit_char)
                                 && $stable(rsp_last_digit))
      else $error("stalled result changed");

   // Every result is a decimal digit character.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_char >= 6'd48) && (rsp_digit_char <= 6'd57))
      else $error("result is not a decimal digit");

   // Once a number is taken, the block is busy in the next cycle.
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second number taken while converting");

   // A number is only taken once the previous run has ended.
   a_run_closed: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid || rsp_last_digit)
      else $error("number taken with a run still open");

endmodule

bind binary_to_decimal_ascii_top bdac_checker u_bdac_checker (.*);
